FILE: design/led_zone_status_renderer_top_macros.svh
// assertion macros used by the renderer controller
`ifndef LED_ZONE_STATUS_RENDERER_TOP_MACROS_SVH
`define LED_ZONE_STATUS_RENDERER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LZSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LZSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lzsr_pkg.sv
// shared constants, codes and command struct of the led zone status renderer
package lzsr_pkg;

  localparam int unsigned ZONES      = 10;
  localparam int unsigned NUM_PIXELS = 256;
  localparam int unsigned PHASE_TOP  = 20;

  localparam int unsigned ZIDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned CNT_W  = (ZIDX_W > 2) ? ZIDX_W : 2;

  // wipe test scale and fade divisor
  localparam int unsigned TWO_T   = 2 * PHASE_TOP;
  localparam int unsigned ON3_DEN = 10 * PHASE_TOP;
  // reciprocal of the fade divisor, exact for dividends below 2^17
  localparam int unsigned    RECIP_SHIFT = 26;
  localparam longint unsigned RECIP_MUL  =
    ((64'd1 << RECIP_SHIFT) + ON3_DEN - 1) / ON3_DEN;

  localparam logic [7:0] LED90_LEVEL = 8'd90;

  // input op codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_BOUNDS = 2'd2;
  localparam logic [1:0] OP_MODE   = 2'd3;

  // zone modes; off and code 7 fall to the background color
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_ON       = 3'd1;
  localparam logic [2:0] MODE_ON2      = 3'd2;
  localparam logic [2:0] MODE_FAILED   = 3'd3;
  localparam logic [2:0] MODE_OK       = 3'd4;
  localparam logic [2:0] MODE_ON3      = 3'd5;
  localparam logic [2:0] MODE_UNSTABLE = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_INTENSITY = 3'd0;
  localparam logic [2:0] CFG_BG_RED        = 3'd1;
  localparam logic [2:0] CFG_BG_GREEN      = 3'd2;
  localparam logic [2:0] CFG_BG_BLUE       = 3'd3;
  localparam logic [2:0] CFG_BG_INTENSITY  = 3'd4;
  localparam logic [2:0] CFG_BG_START      = 3'd5;
  localparam logic [2:0] CFG_BG_END        = 3'd6;

  // scaling unit passes
  localparam logic [1:0] SCALE_RED   = 2'd0;
  localparam logic [1:0] SCALE_GREEN = 2'd1;
  localparam logic [1:0] SCALE_BLUE  = 2'd2;
  localparam logic [1:0] SCALE_LED90 = 2'd3;

  typedef struct packed {
    logic              tick;
    logic              wr_bounds;
    logic              wr_mode;
    logic              load_pix;
    logic              scale_en;
    logic [1:0]        scale_sel;
    logic              scan_en;
    logic              scan_first;
    logic [ZIDX_W-1:0] scan_zone;
    logic              load_out;
  } ctrl_cmd_t;

endpackage

FILE: design/lzsr_datapath.sv
// datapath: config and zone registers, scaling unit, fade pipeline, zone scan
module lzsr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lzsr_pkg::ctrl_cmd_t cmd,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [8:0]          cfg_wdata,
  input  logic [3:0]          in_zone_index,
  input  logic [7:0]          in_zone_first,
  input  logic [8:0]          in_zone_limit,
  input  logic [2:0]          in_zone_mode_in,
  input  logic [7:0]          in_pixel_index,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);
  import lzsr_pkg::*;

  logic [7:0] max_int_r, bg_red_r, bg_green_r, bg_blue_r, bg_int_r, bg_start_r;
  logic [8:0] bg_end_r;

  logic [7:0] zone_lo_r   [ZONES];
  logic [8:0] zone_hi_r   [ZONES];
  logic [2:0] zone_mode_r [ZONES];
  logic [4:0] phase_r;
  logic       rising_r;
  logic       rising_nxt;
  logic [4:0] phase_nxt;
  logic       zone_ok;

  logic [7:0] pix_r;

  // shared scaling unit
  logic [7:0]  sc_a, sc_b;
  logic [15:0] sc_prod;
  logic [16:0] sc_sum;
  logic [7:0]  br_r, bgc_r, bb_r, led90_r;

  // fade level pipeline, runs every cycle
  logic [8:0]  p9;
  logic [16:0] num_r;
  logic [16:0] num_adj;
  logic [39:0] quot_r;
  logic [13:0] drop;
  logic [7:0]  on3_lvl_r;

  // scan stage one
  logic [7:0]  z_lo;
  logic [8:0]  z_hi;
  logic [8:0]  z_len;
  logic [7:0]  z_dlo;
  logic [8:0]  z_dhi;
  logic        z_hit;
  logic        s2_valid_r;
  logic        s2_hit_r;
  logic [2:0]  s2_mode_r;
  logic [13:0] s2_lit_r;
  logic [14:0] s2_dlo_r, s2_dhi_r;
  logic        s2_wipe;

  logic [7:0] acc_r_r, acc_g_r, acc_b_r;
  logic       in_bg;
  logic       in_strip;
  logic [7:0] out_red_r, out_green_r, out_blue_r;

  assign zone_ok = {1'b0, in_zone_index} < 5'(ZONES);

  always_comb begin
    if (phase_r >= 5'(PHASE_TOP)) begin
      rising_nxt = 1'b0;
    end else if (phase_r == 5'd0) begin
      rising_nxt = 1'b1;
    end else begin
      rising_nxt = rising_r;
    end
    phase_nxt = rising_nxt ? phase_r + 5'd1 : phase_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_int_r  <= 8'd100;
      bg_red_r   <= 8'd255;
      bg_green_r <= 8'd255;
      bg_blue_r  <= 8'd170;
      bg_int_r   <= 8'd35;
      bg_start_r <= 8'd3;
      bg_end_r   <= 9'd247;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_INTENSITY: max_int_r  <= cfg_wdata[7:0];
        CFG_BG_RED:        bg_red_r   <= cfg_wdata[7:0];
        CFG_BG_GREEN:      bg_green_r <= cfg_wdata[7:0];
        CFG_BG_BLUE:       bg_blue_r  <= cfg_wdata[7:0];
        CFG_BG_INTENSITY:  bg_int_r   <= cfg_wdata[7:0];
        CFG_BG_START:      bg_start_r <= cfg_wdata[7:0];
        CFG_BG_END:        bg_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int z = 0; z < ZONES; z++) begin
        zone_lo_r[z]   <= '0;
        zone_hi_r[z]   <= '0;
        zone_mode_r[z] <= MODE_OFF;
      end
      phase_r  <= '0;
      rising_r <= 1'b0;
    end else begin
      if (cmd.wr_bounds && zone_ok) begin
        zone_lo_r[in_zone_index[ZIDX_W-1:0]] <= in_zone_first;
        zone_hi_r[in_zone_index[ZIDX_W-1:0]] <= in_zone_limit;
      end
      if (cmd.wr_mode && zone_ok) begin
        zone_mode_r[in_zone_index[ZIDX_W-1:0]] <= in_zone_mode_in;
      end
      if (cmd.tick) begin
        phase_r  <= phase_nxt;
        rising_r <= rising_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_r <= in_pixel_index;
    end
  end

  // floor(a*b/255) as (x + x/256 + 1) / 256, exact for 8x8 products
  always_comb begin
    case (cmd.scale_sel)
      SCALE_RED:   begin sc_a = bg_red_r;    sc_b = bg_int_r;  end
      SCALE_GREEN: begin sc_a = bg_green_r;  sc_b = bg_int_r;  end
      SCALE_BLUE:  begin sc_a = bg_blue_r;   sc_b = bg_int_r;  end
      SCALE_LED90: begin sc_a = LED90_LEVEL; sc_b = max_int_r; end
      default:     begin sc_a = '0;          sc_b = '0;        end
    endcase
    sc_prod = sc_a * sc_b;
    sc_sum  = 17'(sc_prod) + 17'(sc_prod[15:8]) + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      case (cmd.scale_sel)
        SCALE_RED:   br_r    <= sc_sum[15:8];
        SCALE_GREEN: bgc_r   <= sc_sum[15:8];
        SCALE_BLUE:  bb_r    <= sc_sum[15:8];
        SCALE_LED90: led90_r <= sc_sum[15:8];
        default: ;
      endcase
    end
  end

  // fade: m - ceil(9*p*m / den), saturated at zero
  assign p9      = ({4'd0, phase_r} << 3) + {4'd0, phase_r};
  assign num_adj = num_r + 17'(ON3_DEN - 1);
  assign drop    = quot_r[RECIP_SHIFT +: 14];

  always_ff @(posedge clk) begin
    num_r     <= 17'(p9 * max_int_r);
    quot_r    <= 40'(num_adj) * 40'(23'(RECIP_MUL));
    on3_lvl_r <= (drop > 14'(max_int_r)) ? 8'd0 : max_int_r - drop[7:0];
  end

  // scan stage one: zone fetch, cover test, wipe operands
  always_comb begin
    z_lo  = zone_lo_r[cmd.scan_zone];
    z_hi  = zone_hi_r[cmd.scan_zone];
    z_len = z_hi - {1'b0, z_lo};
    z_dlo = pix_r - z_lo;
    z_dhi = z_hi - {1'b0, pix_r};
    z_hit = (z_lo != 8'd0 || z_hi != 9'd0) && (pix_r >= z_lo) && ({1'b0, pix_r} < z_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= cmd.scan_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      s2_hit_r  <= z_hit;
      s2_mode_r <= zone_mode_r[cmd.scan_zone];
      s2_lit_r  <= 14'(z_len * phase_r);
      s2_dlo_r  <= 15'(z_dlo) * 15'(TWO_T);
      s2_dhi_r  <= 15'(z_dhi) * 15'(TWO_T);
    end
  end

  assign s2_wipe  = (s2_dlo_r < 15'(s2_lit_r)) || (s2_dhi_r < 15'(s2_lit_r));
  assign in_bg    = ({1'b0, pix_r} > {1'b0, bg_start_r}) && ({1'b0, pix_r} < bg_end_r);
  assign in_strip = 32'(pix_r) < NUM_PIXELS;

  // scan stage two: later zones overwrite earlier ones
  always_ff @(posedge clk) begin
    if (cmd.scan_first) begin
      acc_r_r <= in_bg ? br_r  : 8'd0;
      acc_g_r <= in_bg ? bgc_r : 8'd0;
      acc_b_r <= in_bg ? bb_r  : 8'd0;
    end else if (s2_valid_r && s2_hit_r) begin
      case (s2_mode_r)
        MODE_FAILED: begin
          acc_r_r <= max_int_r; acc_g_r <= 8'd0; acc_b_r <= 8'd0;
        end
        MODE_UNSTABLE: begin
          acc_r_r <= max_int_r; acc_g_r <= led90_r; acc_b_r <= 8'd0;
        end
        MODE_OK: begin
          acc_r_r <= 8'd0; acc_g_r <= max_int_r; acc_b_r <= 8'd0;
        end
        MODE_ON, MODE_ON2: begin
          acc_r_r <= 8'd0; acc_g_r <= 8'd0; acc_b_r <= s2_wipe ? max_int_r : 8'd0;
        end
        MODE_ON3: begin
          acc_r_r <= 8'd0; acc_g_r <= 8'd0; acc_b_r <= on3_lvl_r;
        end
        default: begin
          acc_r_r <= br_r; acc_g_r <= bgc_r; acc_b_r <= bb_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_red_r   <= in_strip ? acc_r_r : 8'd0;
      out_green_r <= in_strip ? acc_g_r : 8'd0;
      out_blue_r  <= in_strip ? acc_b_r : 8'd0;
    end
  end

  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

FILE: design/lzsr_ctrl.sv
// controller: op decode, query sequencing and output valid
`include "led_zone_status_renderer_top_macros.svh"

module lzsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output lzsr_pkg::ctrl_cmd_t cmd
);
  import lzsr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCALE = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_TICK:   cmd.tick      = 1'b1;
            OP_BOUNDS: cmd.wr_bounds = 1'b1;
            OP_MODE:   cmd.wr_mode   = 1'b1;
            OP_QUERY: begin
              cmd.load_pix = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = S_SCALE;
            end
            default: ;
          endcase
        end
      end
      S_SCALE: begin
        cmd.scale_en  = 1'b1;
        cmd.scale_sel = cnt_r[1:0];
        if (cnt_r[1:0] == SCALE_LED90) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_en    = 1'b1;
        cmd.scan_zone  = cnt_r[ZIDX_W-1:0];
        cmd.scan_first = (cnt_r == '0);
        if (cnt_r == CNT_W'(ZONES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait until the output register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LZSR_ASSERT_IMPL(a_load_needs_room, cmd.load_out, (!out_valid_r || out_ready), "result overwrote a pending transfer")
  `LZSR_ASSERT_IMPL(a_scale_before_scan, cmd.scan_first, $past(cmd.scale_en && cmd.scale_sel == SCALE_LED90), "zone scan started before scaling finished")
  `LZSR_ASSERT_NEXT(a_query_blocks_input, (in_valid && in_ready && in_op == OP_QUERY), (state_r == S_SCALE && !in_ready), "query transfer did not start the render sequence")

endmodule

FILE: design/led_zone_status_renderer_top.sv
// Renders the color of one LED pixel from ten status zones over a background.
// Input channel (in_valid/in_ready) carries ops: tick advances the animation
// phase, set-bounds and set-mode write one zone, query asks for a pixel.
// Only a query produces a transfer on the result channel (out_valid/out_ready)
// with its red, green and blue levels; other ops complete in the cycle they
// are taken. A query is taken, then runs four passes through the shared
// 8x8 scaling multiplier (three background channels and the amber level),
// then a two-stage zone scan at one zone per cycle; the result register then
// loads and the next op is taken in the cycle after, so queries never overlap
// and other ops are taken one per cycle while no query runs. The output
// register holds a finished result while the receiver stalls; ops keep being
// taken meanwhile, and a following query waits at its final step until the
// register is free. Configuration writes via cfg_we, cfg_index and cfg_wdata
// take effect at once; the user must make them only while idle, and the block
// does not enforce it. Synchronous reset loads the register defaults, clears
// all zones to off, sets the phase to zero and empties the output register.
module led_zone_status_renderer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [3:0] in_zone_index,
  input  logic [7:0] in_zone_first,
  input  logic [8:0] in_zone_limit,
  input  logic [2:0] in_zone_mode_in,
  input  logic [7:0] in_pixel_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import lzsr_pkg::*;

  ctrl_cmd_t cmd;

  lzsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lzsr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_zone_index   (in_zone_index),
    .in_zone_first   (in_zone_first),
    .in_zone_limit   (in_zone_limit),
    .in_zone_mode_in (in_zone_mode_in),
    .in_pixel_index  (in_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue)
  );

endmodule

FILE: tb/led_zone_status_renderer_top_tb.sv
// testbench for the led zone status renderer: directed and random ops, checked against a local pixel predictor
module led_zone_status_renderer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzsr_pkg::*;

  // register index that maps to nothing
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int RANDOM_OPS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES = 32;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] zone_idx;
    logic [7:0] first;
    logic [8:0] limit;
    logic [2:0] mode;
    logic [7:0] pix;
  } zone_op_t;

  typedef struct packed {
    logic [7:0] pix;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_color_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = '0;
  logic [3:0] in_zone_index = '0;
  logic [7:0] in_zone_first = '0;
  logic [8:0] in_zone_limit = '0;
  logic [2:0] in_zone_mode_in = '0;
  logic [7:0] in_pixel_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  led_zone_status_renderer_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_zone_index  (in_zone_index),
    .in_zone_first  (in_zone_first),
    .in_zone_limit  (in_zone_limit),
    .in_zone_mode_in(in_zone_mode_in),
    .in_pixel_index (in_pixel_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and zone table
  logic [7:0] status_level, bg_r, bg_g, bg_b, bg_scale, bg_above;
  logic [8:0] bg_below;
  logic [7:0] zone_first_q [ZONES];
  logic [8:0] zone_limit_q [ZONES];
  logic [2:0] zone_mode_q [ZONES];
  logic [4:0] anim_step;
  logic       anim_up;

  zone_op_t     pending_ops [$];
  pixel_color_t expected_colors [$];
  zone_op_t     held_op;
  int           idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int           err_count = 0;

  // track one accepted op; a query yields the color the pixel should show
  function automatic void apply_op(zone_op_t s);
    pixel_color_t c;
    int unsigned  br, bgc, bb, m, i, lo, hi, lit, drop;
    case (s.op)
      OP_TICK: begin
        if (anim_step >= PHASE_TOP) anim_up = 1'b0;
        else if (anim_step == 0) anim_up = 1'b1;
        anim_step = anim_up ? anim_step + 5'd1 : anim_step - 5'd1;
      end
      OP_BOUNDS: begin
        if (s.zone_idx < ZONES) begin
          zone_first_q[s.zone_idx] = s.first;
          zone_limit_q[s.zone_idx] = s.limit;
        end
      end
      OP_MODE: begin
        if (s.zone_idx < ZONES) zone_mode_q[s.zone_idx] = s.mode;
      end
      default: begin
        br  = bg_r * bg_scale / 255;
        bgc = bg_g * bg_scale / 255;
        bb  = bg_b * bg_scale / 255;
        m   = status_level;
        i   = s.pix;
        c.pix = s.pix;
        c.red = '0; c.green = '0; c.blue = '0;
        if (i < NUM_PIXELS) begin
          if (i > bg_above && i < bg_below) begin
            c.red = 8'(br); c.green = 8'(bgc); c.blue = 8'(bb);
          end
          // later zones paint over earlier ones
          for (int z = 0; z < ZONES; z++) begin
            lo = zone_first_q[z];
            hi = zone_limit_q[z];
            if (lo + hi == 0 || i < lo || i >= hi) continue;
            case (zone_mode_q[z])
              MODE_FAILED: begin
                c.red = 8'(m); c.green = '0; c.blue = '0;
              end
              MODE_UNSTABLE: begin
                c.red = 8'(m); c.green = 8'(90 * m / 255); c.blue = '0;
              end
              MODE_OK: begin
                c.red = '0; c.green = 8'(m); c.blue = '0;
              end
              MODE_ON, MODE_ON2: begin
                lit = (hi - lo) * anim_step;
                c.red = '0; c.green = '0;
                c.blue = (2 * PHASE_TOP * (i - lo) < lit || 2 * PHASE_TOP * (hi - i) < lit)
                         ? 8'(m) : 8'd0;
              end
              MODE_ON3: begin
                drop = (9 * anim_step * m + 10 * PHASE_TOP - 1) / (10 * PHASE_TOP);
                c.red = '0; c.green = '0;
                c.blue = (drop > m) ? 8'd0 : 8'(m - drop);
              end
              default: begin
                c.red = 8'(br); c.green = 8'(bgc); c.blue = 8'(bb);
              end
            endcase
          end
        end
        expected_colors.push_back(c);
      end
    endcase
  endfunction

  function automatic void add_op(logic [1:0] op, logic [3:0] zi, logic [7:0] first,
                                 logic [8:0] limit, logic [2:0] mode, logic [7:0] pix);
    zone_op_t s;
    s.op = op; s.zone_idx = zi; s.first = first; s.limit = limit; s.mode = mode; s.pix = pix;
    pending_ops.push_back(s);
  endfunction

  function automatic logic [3:0] pick_zone();
    return ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                    : 4'($urandom_range(ZONES - 1));
  endfunction

  function automatic zone_op_t random_op();
    zone_op_t    s;
    int unsigned pick, z, lo, hi;
    s.zone_idx = 4'($urandom);
    s.first    = 8'($urandom);
    s.limit    = 9'($urandom_range(256));
    s.mode     = 3'($urandom);
    s.pix      = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      s.op = OP_TICK;
    end else if (pick < 70) begin
      s.op = OP_QUERY;
      // half the queries aim at a zone: its first pixel, the one before it, its last pixel or one inside it
      if ($urandom_range(1)) begin
        z  = $urandom_range(ZONES - 1);
        lo = zone_first_q[z];
        hi = zone_limit_q[z];
        case ($urandom_range(3))
          0: s.pix = 8'(lo - 1);
          1: s.pix = 8'(lo);
          2: s.pix = 8'(hi - 1);
          default: s.pix = 8'(lo + $urandom_range(hi > lo ? hi - lo - 1 : 0));
        endcase
      end
    end else if (pick < 85) begin
      s.op = OP_BOUNDS;
      s.zone_idx = pick_zone();
      case ($urandom_range(9))
        0: ;
        1: begin
          s.first = 8'($urandom_range(255, 1));
          s.limit = 9'($urandom_range(s.first));
        end
        2: begin
          s.first = '0;
          s.limit = '0;
        end
        3: s.limit = 9'd256;
        default: begin
          lo = $urandom_range(255);
          hi = lo + $urandom_range(40, 1);
          s.first = 8'(lo);
          s.limit = (hi > 256) ? 9'd256 : 9'(hi);
        end
      endcase
    end else begin
      s.op = OP_MODE;
      s.zone_idx = pick_zone();
    end
    return s;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_INTENSITY: status_level = val[7:0];
      CFG_BG_RED:        bg_r = val[7:0];
      CFG_BG_GREEN:      bg_g = val[7:0];
      CFG_BG_BLUE:       bg_b = val[7:0];
      CFG_BG_INTENSITY:  bg_scale = val[7:0];
      CFG_BG_START:      bg_above = val[7:0];
      CFG_BG_END:        bg_below = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [7:0] lvl, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] scale,
                           input logic [7:0] above, input logic [8:0] below);
    write_reg(CFG_MAX_INTENSITY, {1'b0, lvl});
    write_reg(CFG_BG_RED, {1'b0, r});
    write_reg(CFG_BG_GREEN, {1'b0, g});
    write_reg(CFG_BG_BLUE, {1'b0, b});
    write_reg(CFG_BG_INTENSITY, {1'b0, scale});
    write_reg(CFG_BG_START, {1'b0, above});
    write_reg(CFG_BG_END, below);
  endtask

  // hold off until every op is taken and every color has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: present the next op once the current one is transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_op(held_op);
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 &&
            !((idle_mode == 1 || idle_mode == 3) &&
              $urandom_range(99) < (idle_mode == 1 ? 47 : 9))) begin
          held_op         = pending_ops.pop_front();
          in_op           <= held_op.op;
          in_zone_index   <= held_op.zone_idx;
          in_zone_first   <= held_op.first;
          in_zone_limit   <= held_op.limit;
          in_zone_mode_in <= held_op.mode;
          in_pixel_index  <= held_op.pix;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each color transfer with the oldest prediction
  always @(posedge clk) begin
    pixel_color_t c;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color r=%0d g=%0d b=%0d", $time,
                   out_red, out_green, out_blue);
          err_count++;
        end else begin
          c = expected_colors.pop_front();
          if (out_red !== c.red) begin
            $display("%0t: pixel %0d red exp %0d got %0d", $time, c.pix, c.red, out_red);
            err_count++;
          end
          if (out_green !== c.green) begin
            $display("%0t: pixel %0d green exp %0d got %0d", $time, c.pix, c.green, out_green);
            err_count++;
          end
          if (out_blue !== c.blue) begin
            $display("%0t: pixel %0d blue exp %0d got %0d", $time, c.pix, c.blue, out_blue);
            err_count++;
          end
        end
      end
      out_ready <= !((idle_mode == 2 || idle_mode == 3) &&
                     $urandom_range(99) < (idle_mode == 2 ? 47 : 9));
    end
  end

  initial begin
    status_level = 8'd100;
    bg_r = 8'd255; bg_g = 8'd255; bg_b = 8'd170;
    bg_scale = 8'd35; bg_above = 8'd3; bg_below = 9'd247;
    for (int z = 0; z < ZONES; z++) begin
      zone_first_q[z] = '0;
      zone_limit_q[z] = '0;
      zone_mode_q[z]  = MODE_OFF;
    end
    anim_step = '0;
    anim_up   = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // background edges, zone overlap order, wipe, ignored and empty zones
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd255);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd3);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd4);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd246);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd247);
    add_op(OP_BOUNDS, 4'd0, 8'd0, 9'd256, MODE_OFF, 8'd0);
    add_op(OP_MODE, 4'd0, 8'd0, 9'd0, MODE_FAILED, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd255);
    add_op(OP_BOUNDS, 4'd9, 8'd10, 9'd20, MODE_OFF, 8'd0);
    add_op(OP_MODE, 4'd9, 8'd0, 9'd0, MODE_UNSTABLE, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd15);
    add_op(OP_BOUNDS, 4'd3, 8'd30, 9'd40, MODE_OFF, 8'd0);
    add_op(OP_MODE, 4'd3, 8'd0, 9'd0, MODE_ON, 8'd0);
    add_op(OP_TICK, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd0);
    add_op(OP_TICK, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd30);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd35);
    add_op(OP_BOUNDS, 4'd15, 8'd255, 9'd256, MODE_OFF, 8'd0);
    add_op(OP_MODE, 4'd10, 8'd0, 9'd0, MODE_OK, 8'd0);
    add_op(OP_BOUNDS, 4'd5, 8'd200, 9'd100, MODE_OFF, 8'd0);
    add_op(OP_MODE, 4'd5, 8'd0, 9'd0, MODE_ON3, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd150);
    add_op(OP_MODE, 4'd9, 8'd0, 9'd0, 3'd7, 8'd0);
    add_op(OP_QUERY, 4'd0, 8'd0, 9'd0, MODE_OFF, 8'd15);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0);
        2: load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 9'd256);
        3: begin
          load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom_range(60)), 9'($urandom_range(256, 180)));
          write_reg(CFG_UNUSED, 9'h1ff);
        end
        4: load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 9'($urandom_range(256)));
        5: load_regs(8'd1, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255, 8'd255, 9'd256);
        default: ;
      endcase
      idle_mode = ph % 4;
      @(negedge clk);
      repeat (RANDOM_OPS_PER_PHASE) pending_ops.push_back(random_op());
      drain();
    end

    if (err_count == 0 && expected_colors.size() == 0)
      $display("** led_zone_status_renderer_top: PASSED **");
    else
      $display("** led_zone_status_renderer_top: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** led_zone_status_renderer_top: FAILED **");
    $finish;
  end

endmodule
